// ===== sv/mc3e_request_frame_parser_macros.svh =====
// Assertion macros shared by the frame parser RTL.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef MC3E_REQUEST_FRAME_PARSER_MACROS_SVH
`define MC3E_REQUEST_FRAME_PARSER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define MC3E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the following cycle.
`define MC3E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mc3e_pkg.sv =====
// Types, constants and helpers for the 3E request frame parser.
// No dependencies; used by every module of the block.
`default_nettype none

package mc3e_pkg;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  // Frame byte positions
  localparam logic [15:0] PosLenLo   = 16'd7;
  localparam logic [15:0] PosLenHi   = 16'd8;
  localparam logic [15:0] PosCmdLo   = 16'd11;
  localparam logic [15:0] PosCmdHi   = 16'd14;
  localparam logic [15:0] PosAddr0   = 16'd15;
  localparam logic [15:0] PosAddr1   = 16'd16;
  localparam logic [15:0] PosAddr2   = 16'd17;
  localparam logic [15:0] PosCntLo   = 16'd19;
  localparam logic [15:0] PosCntHi   = 16'd20;
  localparam logic [15:0] MinFrame   = 16'd21;
  localparam logic [15:0] LenFieldEnd = 16'd9;
  localparam logic [15:0] HdrLen     = 16'd7;
  localparam logic [15:0] PosSat     = 16'hFFFF;

  localparam logic [31:0] CmdWrite = 32'h0114_0000;
  localparam logic [31:0] CmdRead  = 32'h0104_0000;

  localparam int unsigned QueueDepth = 2;

  // One queue entry carries everything a single byte can produce:
  // an optional data word followed by an optional frame summary.
  typedef struct packed {
    logic        has_data;
    logic        has_sum;
    logic        ok;
    logic        is_write;
    logic [23:0] reg_address;
    logic [15:0] reg_count;
    logic [15:0] data_word;
    logic [15:0] word_index;
    logic [15:0] words_received;
  } entry_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h50;
      3'd3:    val = 8'hFF;
      3'd4:    val = 8'hFF;
      3'd5:    val = 8'h03;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mc3e_parse.sv =====
// Per-byte frame decode: header/length/command checks and field capture.
// Depends on mc3e_pkg; feeds one entry per producing byte to mc3e_queue.
`default_nettype none

module mc3e_parse import mc3e_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       frame_end_i,
  output logic            push_o,
  output entry_t          entry_o
);

  logic [15:0] pos_q, pos_d;
  logic        mism_q, mism_d;
  logic [15:0] len_q, len_d;
  logic [31:0] cmd_q, cmd_d;
  logic [23:0] addr_q, addr_d;
  logic [15:0] wc_q, wc_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] dws_q, dws_d;
  logic        emit;
  logic        ok;

  always_comb begin
    pos_d  = pos_q;
    mism_d = mism_q;
    len_d  = len_q;
    cmd_d  = cmd_q;
    addr_d = addr_q;
    wc_d   = wc_q;
    low_d  = low_q;
    dws_d  = dws_q;
    emit   = 1'b0;

    if (pos_q < HdrLen) begin
      if (rx_byte_i != hdr_byte(pos_q[2:0])) mism_d = 1'b1;
    end else if (pos_q == PosLenLo) begin
      len_d = {8'h00, rx_byte_i};
    end else if (pos_q == PosLenHi) begin
      len_d = len_q | {rx_byte_i, 8'h00};
    end else if (pos_q >= PosCmdLo && pos_q <= PosCmdHi) begin
      cmd_d = {cmd_q[23:0], rx_byte_i};
    end else if (pos_q == PosAddr0) begin
      addr_d = addr_q | {16'h0000, rx_byte_i};
    end else if (pos_q == PosAddr1) begin
      addr_d = addr_q | {8'h00, rx_byte_i, 8'h00};
    end else if (pos_q == PosAddr2) begin
      addr_d = addr_q | {rx_byte_i, 16'h0000};
    end else if (pos_q == PosCntLo) begin
      wc_d = {8'h00, rx_byte_i};
    end else if (pos_q == PosCntHi) begin
      wc_d = wc_q | {rx_byte_i, 8'h00};
    end else if (pos_q >= MinFrame && pos_q != PosSat) begin
      // data starts at an odd position: odd = low byte, even = high byte
      if (pos_q[0]) begin
        low_d = rx_byte_i;
      end else if (!mism_q && cmd_q == CmdWrite && dws_q < wc_q) begin
        emit  = 1'b1;
        dws_d = dws_q + 16'd1;
      end
    end

    if (pos_q != PosSat) pos_d = pos_q + 16'd1;
  end

  // Length field counts the bytes after itself: pos + 1 - 9.
  always_comb begin
    ok = (pos_q != PosSat) && (pos_q >= (MinFrame - 16'd1)) && !mism_d &&
         (len_d == pos_q + 16'd1 - LenFieldEnd) &&
         (cmd_d == CmdWrite || cmd_d == CmdRead);
  end

  always_comb begin
    entry_o.has_data       = emit;
    entry_o.has_sum        = frame_end_i;
    entry_o.ok             = ok;
    entry_o.is_write       = (cmd_d == CmdWrite);
    entry_o.reg_address    = addr_d;
    entry_o.reg_count      = wc_d;
    entry_o.data_word      = {rx_byte_i, low_q};
    entry_o.word_index     = dws_q;
    entry_o.words_received = dws_d;
  end

  assign push_o = accept_i && (emit || frame_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mism_q <= 1'b0;
      len_q  <= '0;
      cmd_q  <= '0;
      addr_q <= '0;
      wc_q   <= '0;
      low_q  <= '0;
      dws_q  <= '0;
    end else if (accept_i && frame_end_i) begin
      pos_q  <= '0;
      mism_q <= 1'b0;
      len_q  <= '0;
      cmd_q  <= '0;
      addr_q <= '0;
      wc_q   <= '0;
      low_q  <= '0;
      dws_q  <= '0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      mism_q <= mism_d;
      len_q  <= len_d;
      cmd_q  <= cmd_d;
      addr_q <= addr_d;
      wc_q   <= wc_d;
      low_q  <= low_d;
      dws_q  <= dws_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mc3e_queue.sv =====
// Result queue: holds decoded entries and splits each into data/summary words.
// Depends on mc3e_pkg and the assertion macro header.
`default_nettype none

`include "mc3e_request_frame_parser_macros.svh"

module mc3e_queue import mc3e_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire entry_t      entry_i,
  output logic             not_full_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic             is_write_o,
  output logic [23:0]      reg_address_o,
  output logic [15:0]      reg_count_o,
  output logic [15:0]      data_word_o,
  output logic [15:0]      word_index_o,
  output logic [15:0]      words_received_o,
  output logic             last_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              part_q;   // data word of head already delivered
  entry_t            head;
  logic              show_data;
  logic              out_fire;
  logic              pop;
  kind_e             kind;

  assign head        = mem_q[rd_ptr_q];
  assign not_full_o  = (count_q < CntW'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign show_data   = head.has_data && !part_q;
  assign out_fire    = out_valid_o && out_ready_i;
  assign pop         = out_fire && (!show_data || !head.has_sum);

  always_comb begin
    if (show_data)    kind = KIND_DATA;
    else if (head.ok) kind = KIND_ACCEPT;
    else              kind = KIND_REJECT;
  end

  assign result_kind_o    = kind;
  assign is_write_o       = head.is_write;
  assign reg_address_o    = head.reg_address;
  assign reg_count_o      = head.reg_count;
  assign data_word_o      = show_data ? head.data_word : 16'h0000;
  assign word_index_o     = show_data ? head.word_index : 16'h0000;
  assign words_received_o = show_data ? 16'h0000 : head.words_received;
  assign last_o           = show_data ? !head.has_sum : 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      part_q   <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
        part_q   <= 1'b0;
      end else if (out_fire) begin
        part_q   <= 1'b1;
      end
      if (push_i && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push_i) count_q <= count_q - 1'b1;
    end
  end

  `MC3E_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "queue count over depth")
  `MC3E_ASSERT(a_no_push_full, !push_i || not_full_o, "push into full queue")
  `MC3E_ASSERT(a_part_valid, !part_q || (out_valid_o && head.has_data && head.has_sum),
               "split flag set without a two-word head")
  `MC3E_ASSERT_NEXT(a_drain_empty, pop && !push_i && count_q == CntW'(1), !out_valid_o,
                    "queue not empty after last pop")

endmodule

`default_nettype wire

// ===== sv/mc3e_request_frame_parser.sv =====
// Binary 3E-style request frame parser, one frame byte per word. Each byte is
// decoded in the cycle it is accepted; a byte completing a write data word
// yields a data word, and the frame's last byte yields an accept/reject
// summary (after the data word if both fall on that byte, only the summary
// has last set). Input throughput is one byte per cycle while the queue has
// room; the result queue of QUEUE_DEPTH entries decouples the sides, and
// in_ready_o drops only when the queue is full. A byte producing two words is
// delivered as two transfers; all results pass through the queue registers.
`default_nettype none

module mc3e_request_frame_parser import mc3e_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               frame_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              result_kind_o,
  output logic                    is_write_o,
  output logic [23:0]             reg_address_o,
  output logic [15:0]             reg_count_o,
  output logic signed [15:0]      data_word_o,
  output logic [15:0]             word_index_o,
  output logic [15:0]             words_received_o,
  output logic                    last_o
);

  logic       accept;
  logic       push;
  entry_t     entry;
  logic [15:0] data_word_raw;

  assign accept = in_valid_i && in_ready_o;

  mc3e_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .push_o      (push),
    .entry_o     (entry)
  );

  mc3e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .entry_i          (entry),
    .not_full_o       (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .is_write_o       (is_write_o),
    .reg_address_o    (reg_address_o),
    .reg_count_o      (reg_count_o),
    .data_word_o      (data_word_raw),
    .word_index_o     (word_index_o),
    .words_received_o (words_received_o),
    .last_o           (last_o)
  );

  assign data_word_o = $signed(data_word_raw);

endmodule

`default_nettype wire
